// ===== hw/rtl/mph_pkg.sv =====
`timescale 1ns / 1ps
package mph_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned HashW    = 32;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_FIND   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_TX_SEQ = 3'd3,
    ACT_RX_SEQ = 3'd4,
    ACT_SETKEY = 3'd5,
    ACT_ROUTES = 3'd6
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HASH,
    ST_LK_RD,
    ST_LK_CMP,
    ST_EXEC,
    ST_INS,
    ST_VS_RD,
    ST_VS_CMP,
    ST_VS_END,
    ST_RM_CLR,
    ST_RM_CHK,
    ST_RM_LATCH,
    ST_RM_HASH,
    ST_RM_PROBE
  } state_e;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] last_seen;
    logic [15:0] tx_seq;
    logic [15:0] rx_seq;
    logic        key_flag;
    logic [7:0]  epoch;
    logic [7:0]  routes;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] mac;
    logic [31:0] now;
    logic [15:0] seq;
    logic [7:0]  epoch;
    logic [7:0]  route_count;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [15:0] seq_out;
    logic [4:0]  peer_count;
    logic        evicted;
    logic        key_set;
    logic [7:0]  epoch_out;
  } rsp_t;

endpackage

// ===== hw/rtl/mph_hash.sv =====
`timescale 1ns / 1ps
module mph_hash #(
  parameter int unsigned SLOTS = mph_pkg::SlotsDef,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mph_pkg::HashW-1:0] key_i,
  output logic                      done_o,
  output logic [IW-1:0]             home_o
);
  import mph_pkg::*;

  localparam bit IsPow2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam int unsigned SumW  = 18;
  localparam int unsigned RcpW  = 20;
  localparam int unsigned Sh    = SumW + IW;
  localparam int unsigned PrdW  = SumW + Sh;
  localparam int unsigned BackW = SumW + 9;
  localparam logic [7:0]  Wt1   = 8'((32'd1 << 8) % SLOTS);
  localparam logic [7:0]  Wt2   = 8'((32'd1 << 16) % SLOTS);
  localparam logic [7:0]  Wt3   = 8'((32'd1 << 24) % SLOTS);
  localparam logic [RcpW-1:0] Rcp =
    RcpW'(((64'd1 << Sh) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [8:0]  Div   = 9'(SLOTS);

  logic [2:0]       v_q, v_d;
  logic [SumW-1:0]  fold_q, fold_d;
  logic [SumW-1:0]  quo_q, quo_d;
  logic [IW-1:0]    r_q, r_d;
  logic [15:0]      p1, p2, p3;
  logic [PrdW-1:0]  prod;
  logic [BackW-1:0] back;
  logic [SumW-1:0]  rem;

  // Fold the key bytes by their weights mod SLOTS, then reduce the sum with
  // a reciprocal multiply and one subtract; a power-of-two SLOTS takes the key's low bits.
  always_comb begin
    v_d    = {v_q[1:0], start_i};
    fold_d = fold_q;
    quo_d  = quo_q;
    r_d    = r_q;
    p1     = {8'b0, key_i[15:8]} * {8'b0, Wt1};
    p2     = {8'b0, key_i[23:16]} * {8'b0, Wt2};
    p3     = {8'b0, key_i[31:24]} * {8'b0, Wt3};
    prod   = PrdW'(fold_q) * PrdW'(Rcp);
    back   = BackW'(quo_q) * BackW'(Div);
    rem    = fold_q - back[SumW-1:0];
    if (start_i) begin
      fold_d = SumW'(key_i[7:0]) + SumW'(p1) + SumW'(p2) + SumW'(p3);
      if (IsPow2) r_d = key_i[IW-1:0];
    end
    if (v_q[0]) quo_d = prod[Sh +: SumW];
    if (v_q[1] && !IsPow2) r_d = rem[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
    quo_q  <= quo_d;
    r_q    <= r_d;
  end

  assign done_o = IsPow2 ? v_q[0] : v_q[2];
  assign home_o = r_q;

endmodule

// ===== hw/rtl/mph_mem.sv =====
`timescale 1ns / 1ps
module mph_mem #(
  parameter int unsigned SLOTS = mph_pkg::SlotsDef,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [IW-1:0]     addr_i,
  input  mph_pkg::entry_t   wdata_i,
  output mph_pkg::entry_t   rdata_o
);
  import mph_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem_q[addr_i] <= wdata_i;
      else      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mac_peer_hash_table.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------
// request   | start / busy       | req_i  (action, mac, now, ...)
// result    | done_o strobe      | rsp_o  (ok, slot, peer_count, ...)
//
// One request at a time; busy stays high until its result strobes.
// Hash: the key's low bits if SLOTS is a power of two, else fold, multiply, subtract.
// Lookup reads, then compares, each probed slot; an insert probes slots from
// the home slot; a full-table eviction scan reads every slot; the cluster
// rehash after a remove reads, rehashes and re-probes each moved entry.
// Reset clears valid bits and the peer count at once; no clearing pass.
// The receiver cannot stall: done_o is high for exactly one cycle.
module mac_peer_hash_table #(
  parameter int unsigned SLOTS = mph_pkg::SlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mph_pkg::req_t req_i,
  output logic          done_o,
  output mph_pkg::rsp_t rsp_o
);
  import mph_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);
  localparam logic [CW-1:0] NSlots  = CW'(SLOTS);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  entry_t ent_q, ent_d;
  rsp_t   rsp_q, rsp_d;
  logic   done_q, done_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0] cnt_q, cnt_d;     // valid entries
  logic [CW-1:0] n_q, n_d;         // probe steps
  logic [IW-1:0] h_q, h_d;         // home slot of the request
  logic [IW-1:0] p_q, p_d;         // probe index
  logic [IW-1:0] idx_q, idx_d;     // hit / victim slot
  logic [IW-1:0] pos_q, pos_d;     // rehash walk position
  logic [IW-1:0] np_q, np_d;       // rehash target probe
  logic          found_q, found_d;
  logic          evict_q, evict_d;
  logic [31:0]   best0_q, best0_d, best1_q, best1_d;
  logic          has0_q, has0_d, has1_q, has1_d;
  logic [IW-1:0] c0_q, c0_d, c1_q, c1_d;

  logic          hs_start, hs_done;
  logic [HashW-1:0] hs_key;
  logic [IW-1:0] hs_home;
  logic          m_en, m_we;
  logic [IW-1:0] m_addr;
  entry_t        m_wdata, m_rdata;
  logic [15:0]   rx_diff;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] x);
    return (x == LastIdx) ? '0 : x + 1'b1;
  endfunction

  function automatic rsp_t mk_rsp(input logic ok, input logic [IW-1:0] s,
                                  input logic [15:0] sq, input logic [CW-1:0] c,
                                  input logic ev, input logic k, input logic [7:0] ep);
    rsp_t r;
    logic [IW+3:0] sw;
    logic [CW+4:0] cw;
    sw = {4'b0, s};
    cw = {5'b0, c};
    r.ok         = ok;
    r.slot       = ok ? sw[3:0] : 4'b0;
    r.seq_out    = sq;
    r.peer_count = cw[4:0];
    r.evicted    = ev;
    r.key_set    = k;
    r.epoch_out  = ep;
    return r;
  endfunction

  mph_hash #(.SLOTS(SLOTS), .IW(IW)) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hs_start),
    .key_i  (hs_key),
    .done_o (hs_done),
    .home_o (hs_home)
  );

  mph_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk_i  (clk_i),
    .en_i   (m_en),
    .we_i   (m_we),
    .addr_i (m_addr),
    .wdata_i(m_wdata),
    .rdata_o(m_rdata)
  );

  assign rx_diff = req_q.seq - ent_q.rx_seq;

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    ent_d   = ent_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    h_d     = h_q;
    p_d     = p_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    np_d    = np_q;
    found_d = found_q;
    evict_d = evict_q;
    best0_d = best0_q;
    best1_d = best1_q;
    has0_d  = has0_q;
    has1_d  = has1_q;
    c0_d    = c0_q;
    c1_d    = c1_q;
    hs_start = 1'b0;
    hs_key   = req_q.mac[HashW-1:0];
    m_en     = 1'b0;
    m_we     = 1'b0;
    m_addr   = p_q;
    m_wdata  = ent_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d    = req_i;
          evict_d  = 1'b0;
          hs_start = 1'b1;
          hs_key   = req_i.mac[HashW-1:0];
          state_d  = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hs_done) begin
          h_d     = hs_home;
          p_d     = hs_home;
          n_d     = '0;
          state_d = ST_LK_RD;
        end
      end
      // Walk the probe chain; stop at a match, at a hole or after a full lap.
      ST_LK_RD: begin
        if (n_q == NSlots || !valid_q[p_q]) begin
          found_d = 1'b0;
          state_d = ST_EXEC;
        end else begin
          m_en    = 1'b1;
          state_d = ST_LK_CMP;
        end
      end
      ST_LK_CMP: begin
        ent_d = m_rdata;
        if (m_rdata.mac == req_q.mac) begin
          found_d = 1'b1;
          idx_d   = p_q;
          state_d = ST_EXEC;
        end else begin
          p_d     = inc(p_q);
          n_d     = n_q + 1'b1;
          state_d = ST_LK_RD;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        rsp_d   = mk_rsp(1'b0, '0, 16'h0, cnt_q, 1'b0, 1'b0, 8'h0);
        m_addr  = idx_q;
        unique case (action_e'(req_q.action))
          ACT_ADD: begin
            if (found_q) begin
              m_en = 1'b1;
              m_we = 1'b1;
              m_wdata.last_seen = req_q.now;
              rsp_d = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, ent_q.key_flag, ent_q.epoch);
            end else begin
              // hold the strobe and go look for a free slot
              done_d  = 1'b0;
              p_d     = h_q;
              n_d     = '0;
              state_d = ST_INS;
            end
          end
          ACT_FIND: begin
            if (found_q) begin
              rsp_d = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, ent_q.key_flag, ent_q.epoch);
            end
          end
          ACT_REMOVE: begin
            if (found_q) begin
              done_d  = 1'b0;
              state_d = ST_RM_CLR;
            end
          end
          ACT_TX_SEQ: begin
            if (found_q) begin
              m_en = 1'b1;
              m_we = 1'b1;
              m_wdata.tx_seq = ent_q.tx_seq + 16'd1;
              rsp_d = mk_rsp(1'b1, idx_q, ent_q.tx_seq + 16'd1, cnt_q, 1'b0,
                             ent_q.key_flag, ent_q.epoch);
            end
          end
          ACT_RX_SEQ: begin
            // accept only a sequence strictly ahead in the 16-bit window
            if (found_q && rx_diff != 16'h0 && !rx_diff[15]) begin
              m_en = 1'b1;
              m_we = 1'b1;
              m_wdata.rx_seq = req_q.seq;
              rsp_d = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, ent_q.key_flag, ent_q.epoch);
            end
          end
          ACT_SETKEY: begin
            if (found_q) begin
              m_en = 1'b1;
              m_we = 1'b1;
              m_wdata.epoch    = req_q.epoch;
              m_wdata.key_flag = 1'b1;
              m_wdata.tx_seq   = 16'h0;
              m_wdata.rx_seq   = 16'h0;
              rsp_d = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, 1'b1, req_q.epoch);
            end
          end
          ACT_ROUTES: begin
            if (found_q) begin
              m_en = 1'b1;
              m_we = 1'b1;
              m_wdata.routes = req_q.route_count;
              rsp_d = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, ent_q.key_flag, ent_q.epoch);
            end
          end
          default: ;
        endcase
      end
      // Insert a fresh entry at the first hole from the home slot; on a full lap, scan for a victim.
      ST_INS: begin
        if (n_q == NSlots) begin
          p_d     = '0;
          n_d     = '0;
          best0_d = AllOnes;
          best1_d = AllOnes;
          has0_d  = 1'b0;
          has1_d  = 1'b0;
          state_d = ST_VS_RD;
        end else if (!valid_q[p_q]) begin
          m_en    = 1'b1;
          m_we    = 1'b1;
          m_wdata = '0;
          m_wdata.mac       = req_q.mac;
          m_wdata.last_seen = req_q.now;
          valid_d[p_q] = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          rsp_d   = mk_rsp(1'b1, p_q, 16'h0, cnt_q + 1'b1, evict_q, 1'b0, 8'h0);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          p_d = inc(p_q);
          n_d = n_q + 1'b1;
        end
      end
      // Victim scan: track oldest route-free and oldest overall in one pass.
      ST_VS_RD: begin
        if (n_q == NSlots) begin
          state_d = ST_VS_END;
        end else begin
          m_en    = 1'b1;
          state_d = ST_VS_CMP;
        end
      end
      ST_VS_CMP: begin
        if (valid_q[p_q]) begin
          if (m_rdata.routes == 8'h0 && m_rdata.last_seen < best0_q) begin
            best0_d = m_rdata.last_seen;
            has0_d  = 1'b1;
            c0_d    = p_q;
          end
          if (m_rdata.last_seen < best1_q) begin
            best1_d = m_rdata.last_seen;
            has1_d  = 1'b1;
            c1_d    = p_q;
          end
        end
        p_d     = inc(p_q);
        n_d     = n_q + 1'b1;
        state_d = ST_VS_RD;
      end
      ST_VS_END: begin
        if (has0_q || has1_q) begin
          idx_d   = has0_q ? c0_q : c1_q;
          evict_d = 1'b1;
          state_d = ST_RM_CLR;
        end else begin
          rsp_d   = mk_rsp(1'b0, '0, 16'h0, cnt_q, 1'b0, 1'b0, 8'h0);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      // Remove: drop the slot, then re-place every entry of the cluster after it; an eviction then inserts.
      ST_RM_CLR: begin
        valid_d[idx_q] = 1'b0;
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        pos_d   = inc(idx_q);
        state_d = ST_RM_CHK;
      end
      ST_RM_CHK: begin
        if (!valid_q[pos_q]) begin
          if (evict_q) begin
            p_d     = h_q;
            n_d     = '0;
            state_d = ST_INS;
          end else begin
            rsp_d   = mk_rsp(1'b1, idx_q, 16'h0, cnt_q, 1'b0, 1'b0, 8'h0);
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          m_en    = 1'b1;
          m_addr  = pos_q;
          state_d = ST_RM_LATCH;
        end
      end
      ST_RM_LATCH: begin
        ent_d          = m_rdata;
        hs_start       = 1'b1;
        hs_key         = m_rdata.mac[HashW-1:0];
        valid_d[pos_q] = 1'b0;
        state_d        = ST_RM_HASH;
      end
      ST_RM_HASH: begin
        if (hs_done) begin
          np_d    = hs_home;
          state_d = ST_RM_PROBE;
        end
      end
      ST_RM_PROBE: begin
        if (!valid_q[np_q]) begin
          m_en          = 1'b1;
          m_we          = 1'b1;
          m_addr        = np_q;
          valid_d[np_q] = 1'b1;
          pos_d         = inc(pos_q);
          state_d       = ST_RM_CHK;
        end else begin
          np_d = inc(np_q);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      valid_q <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      evict_q <= 1'b0;
      has0_q  <= 1'b0;
      has1_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      evict_q <= evict_d;
      has0_q  <= has0_d;
      has1_q  <= has1_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ent_q   <= ent_d;
    rsp_q   <= rsp_d;
    h_q     <= h_d;
    p_q     <= p_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    np_q    <= np_d;
    best0_q <= best0_d;
    best1_q <= best1_d;
    c0_q    <= c0_d;
    c1_q    <= c1_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
